### sv/btb_pkg.sv
`timescale 1ns / 1ps
// btb_pkg: shared types and constants of the block transpose buffer
// no dependencies; imported by every module of the block but btb_ram

package btb_pkg;

  // fixed field widths
  localparam int CFG_W  = 7;
  localparam int BASE_W = 31;

  // defaults for the top level parameters
  localparam int DEF_MAX_DIM      = 80;
  localparam int DEF_ELEMENT_BITS = 64;

  // words that may sit between front and back
  localparam int QUEUE_DEPTH = 4;

  // command carried in tuser bit 0
  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_READ = 1'b1
  } btb_cmd_t;

  // register index, taken from paddr bit 2
  typedef enum logic {
    REG_ROWS = 1'b0,
    REG_COLS = 1'b1
  } btb_reg_t;

  // side information that travels with each result word
  typedef struct packed {
    logic [BASE_W-1:0] base;
    logic              last;
    logic              batch;
  } btb_tag_t;

endpackage

### sv/block_transpose_buffer_unit.sv
`timescale 1ns / 1ps
// block_transpose_buffer_unit: corner-turn buffer for one rows x cols block
// loads take effect at the accepting edge; a read word passes the read stage, the queue and the
// output register before it raises m_tvalid; one word per cycle sustained while m_tready is high
// reset (synchronous, rst high) clears counters, read position, queue and output valid;
// rows and cols reset to 1; the element store is not cleared
// depends on btb_pkg, btb_front, btb_ram, btb_fifo, btb_back

module block_transpose_buffer_unit #(
  parameter int MAX_DIM      = btb_pkg::DEF_MAX_DIM,
  parameter int ELEMENT_BITS = btb_pkg::DEF_ELEMENT_BITS
) (
  input  logic        clk,
  input  logic        rst,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // slave side
  input  logic        s_tvalid,
  output logic        s_tready,
  // element_value, block_base, zero fill
  input  logic [((ELEMENT_BITS + btb_pkg::BASE_W + 7) / 8) * 8 - 1:0] s_tdata,
  // command, end_of_batch
  input  logic [1:0]  s_tuser,
  // master side
  output logic        m_tvalid,
  input  logic        m_tready,
  // out_value, out_base, zero fill
  output logic [((ELEMENT_BITS + btb_pkg::BASE_W + 7) / 8) * 8 - 1:0] m_tdata,
  // last_in_block
  output logic        m_tlast,
  // last_of_batch
  output logic [0:0]  m_tuser
);
  import btb_pkg::*;

  localparam int DATA_W = ((ELEMENT_BITS + BASE_W + 7) / 8) * 8;
  localparam int QC_W   = $clog2(QUEUE_DEPTH + 1);

  logic [CFG_W-1:0]        rows;
  logic [CFG_W-1:0]        cols;
  logic [CFG_W-1:0]        wr_dim;
  btb_reg_t                reg_sel;
  logic                    cfg_we;

  logic                    push;
  logic [ELEMENT_BITS-1:0] push_value;
  btb_tag_t                push_tag;
  logic                    pop;
  logic                    q_valid;
  logic [ELEMENT_BITS-1:0] q_value;
  btb_tag_t                q_tag;
  logic [QC_W-1:0]         q_count;
  logic [ELEMENT_BITS-1:0] out_value;
  btb_tag_t                out_tag;

  // register decode and dimension clipping
  assign pready  = 1'b1;
  assign reg_sel = btb_reg_t'(paddr[2]);
  assign cfg_we  = psel && penable && pwrite && pready;

  always_comb begin
    wr_dim = pwdata[CFG_W-1:0];
    if (int'(pwdata[CFG_W-1:0]) > MAX_DIM) begin
      wr_dim = CFG_W'(MAX_DIM);
    end
    if (pwdata[CFG_W-1:0] == '0) begin
      wr_dim = CFG_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rows <= CFG_W'(1);
      cols <= CFG_W'(1);
    end else if (cfg_we) begin
      case (reg_sel)
        REG_ROWS: rows <= wr_dim;
        REG_COLS: cols <= wr_dim;
        default:  rows <= rows;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (reg_sel)
      REG_ROWS: prdata = 32'(rows);
      REG_COLS: prdata = 32'(cols);
      default:  prdata = '0;
    endcase
  end

  btb_front #(
    .MAX_DIM      (MAX_DIM),
    .ELEMENT_BITS (ELEMENT_BITS),
    .QDEPTH       (QUEUE_DEPTH)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .rows          (rows),
    .cols          (cols),
    .in_valid      (s_tvalid),
    .in_ready      (s_tready),
    .command       (btb_cmd_t'(s_tuser[0])),
    .element_value (s_tdata[ELEMENT_BITS-1:0]),
    .block_base    (s_tdata[ELEMENT_BITS +: BASE_W]),
    .end_of_batch  (s_tuser[1]),
    .q_count       (q_count),
    .push          (push),
    .push_value    (push_value),
    .push_tag      (push_tag)
  );

  btb_fifo #(
    .VAL_W (ELEMENT_BITS),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_value (push_value),
    .push_tag   (push_tag),
    .pop        (pop),
    .q_valid    (q_valid),
    .q_value    (q_value),
    .q_tag      (q_tag),
    .count      (q_count)
  );

  btb_back #(
    .VAL_W (ELEMENT_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_value   (q_value),
    .q_tag     (q_tag),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_value (out_value),
    .out_tag   (out_tag)
  );

  // master side packing
  assign m_tdata    = DATA_W'({out_tag.base, out_value});
  assign m_tlast    = out_tag.last;
  assign m_tuser[0] = out_tag.batch;

endmodule

### sv/btb_ram.sv
`timescale 1ns / 1ps
// btb_ram: generic single-port RAM with registered read data
// no dependencies

module btb_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 6400
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read, read-first
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### sv/btb_fifo.sv
`timescale 1ns / 1ps
// btb_fifo: short queue of result words between front and back
// depends on btb_pkg (btb_tag_t)

module btb_fifo #(
  parameter int VAL_W = 64,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [VAL_W-1:0]           push_value,
  input  btb_pkg::btb_tag_t          push_tag,
  input  logic                       pop,
  output logic                       q_valid,
  output logic [VAL_W-1:0]           q_value,
  output btb_pkg::btb_tag_t          q_tag,
  output logic [$clog2(DEPTH+1)-1:0] count
);
  import btb_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [VAL_W-1:0] value_mem [DEPTH];
  btb_tag_t         tag_mem   [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic             do_pop;

  assign q_valid = (count != '0);
  assign q_value = value_mem[rd_ptr];
  assign q_tag   = tag_mem[rd_ptr];
  assign do_pop  = pop && q_valid;

  // storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      value_mem[wr_ptr] <= push_value;
      tag_mem[wr_ptr]   <= push_tag;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### sv/btb_front.sv
`timescale 1ns / 1ps
// btb_front: accepts words, loads the element store, walks the transposed order
// depends on btb_pkg and btb_ram; feeds btb_fifo

module btb_front #(
  parameter int MAX_DIM      = btb_pkg::DEF_MAX_DIM,
  parameter int ELEMENT_BITS = btb_pkg::DEF_ELEMENT_BITS,
  parameter int QDEPTH       = btb_pkg::QUEUE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [btb_pkg::CFG_W-1:0]     rows,
  input  logic [btb_pkg::CFG_W-1:0]     cols,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  btb_pkg::btb_cmd_t             command,
  input  logic [ELEMENT_BITS-1:0]       element_value,
  input  logic [btb_pkg::BASE_W-1:0]    block_base,
  input  logic                          end_of_batch,
  input  logic [$clog2(QDEPTH+1)-1:0]   q_count,
  output logic                          push,
  output logic [ELEMENT_BITS-1:0]       push_value,
  output btb_pkg::btb_tag_t             push_tag
);
  import btb_pkg::*;

  localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
  localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
  localparam int POS_W       = $clog2(MAX_DIM + 1);
  localparam int SZ_W        = (CNT_W > 2 * CFG_W) ? CNT_W : 2 * CFG_W;
  localparam int IDX_W       = POS_W + CFG_W + 1;
  localparam int CMP_W       = POS_W + CFG_W;
  localparam int QC_W        = $clog2(QDEPTH + 1);

  // block state
  logic [CNT_W-1:0]  load_count;
  logic [POS_W-1:0]  read_row;
  logic [POS_W-1:0]  read_col;
  logic              block_full;
  logic [BASE_W-1:0] held_base;
  logic              held_end;

  // read stage waiting for ram data
  logic              s1_valid;
  logic              s1_zero;
  btb_tag_t          s1_tag;

  logic              accept;
  logic [SZ_W-1:0]   size;
  logic              full;
  logic [IDX_W-1:0]  idx;
  logic              idx_ok;
  logic [POS_W-1:0]  col_inc;
  logic [POS_W-1:0]  row_inc;
  logic              col_wrap;
  logic              row_wrap;
  logic              do_load;
  logic              do_read;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [ELEMENT_BITS-1:0] ram_rdata;

  // room for this word and the one still in the read stage
  assign in_ready = ({1'b0, q_count} + (QC_W + 1)'(s1_valid)) < (QC_W + 1)'(QDEPTH);
  assign accept   = in_valid && in_ready;

  // block size and fullness against current dimensions
  assign size = SZ_W'(rows) * SZ_W'(cols);
  assign full = block_full || (SZ_W'(load_count) >= size);

  // store index of the next transposed element
  assign idx    = IDX_W'(read_col) * IDX_W'(rows) + IDX_W'(read_row);
  assign idx_ok = idx < IDX_W'(STORE_DEPTH);

  // position stepping in row-major order
  assign col_inc  = read_col + 1'b1;
  assign row_inc  = read_row + 1'b1;
  assign col_wrap = CMP_W'(col_inc) >= CMP_W'(cols);
  assign row_wrap = CMP_W'(row_inc) >= CMP_W'(rows);

  assign do_load = accept && (command == CMD_LOAD) && !full;
  assign do_read = accept && (command == CMD_READ) && full;

  // ram port: loads write in column-major order, reads follow the walk
  assign ram_we   = do_load && (load_count < CNT_W'(STORE_DEPTH));
  assign ram_addr = (command == CMD_LOAD) ? load_count[ADDR_W-1:0] : idx[ADDR_W-1:0];

  btb_ram #(
    .WIDTH (ELEMENT_BITS),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (element_value),
    .rdata (ram_rdata)
  );

  // word to the queue once ram data is back
  assign push       = s1_valid;
  assign push_value = s1_zero ? '0 : ram_rdata;
  assign push_tag   = s1_tag;

  // read stage payload
  always_ff @(posedge clk) begin
    if (do_read) begin
      s1_zero     <= !idx_ok;
      s1_tag.base <= held_base;
      s1_tag.last <= col_wrap && row_wrap;
      s1_tag.batch <= col_wrap && row_wrap && held_end;
    end
  end

  // block control
  always_ff @(posedge clk) begin
    if (rst) begin
      load_count <= '0;
      read_row   <= '0;
      read_col   <= '0;
      block_full <= 1'b0;
      held_base  <= '0;
      held_end   <= 1'b0;
      s1_valid   <= 1'b0;
    end else begin
      s1_valid <= do_read;
      if (accept) begin
        block_full <= full;
      end
      if (do_load) begin
        if (load_count == '0) begin
          held_base <= block_base;
          held_end  <= end_of_batch;
        end
        load_count <= load_count + 1'b1;
        block_full <= (SZ_W'(load_count) + 1'b1) >= size;
      end
      if (do_read) begin
        if (col_wrap) begin
          read_col <= '0;
          if (row_wrap) begin
            read_row   <= '0;
            load_count <= '0;
            block_full <= 1'b0;
          end else begin
            read_row <= row_inc;
          end
        end else begin
          read_col <= col_inc;
        end
      end
    end
  end

endmodule

### sv/btb_back.sv
`timescale 1ns / 1ps
// btb_back: output register that drains the queue onto the master side
// depends on btb_pkg (btb_tag_t)

module btb_back #(
  parameter int VAL_W = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  logic [VAL_W-1:0]  q_value,
  input  btb_pkg::btb_tag_t q_tag,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [VAL_W-1:0]  out_value,
  output btb_pkg::btb_tag_t out_tag
);
  import btb_pkg::*;

  // take the next word when the register is empty or being drained
  assign pop = q_valid && (!out_valid || out_ready);

  // output payload
  always_ff @(posedge clk) begin
    if (pop) begin
      out_value <= q_value;
      out_tag   <= q_tag;
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule
